>>> hdl/paged_first_fit_heap_allocator_assert.svh
// Assertion macros for the paged heap allocator.
`ifndef PAGED_FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define PAGED_FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFFHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, checked out of reset.
`define PFFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

>>> hdl/pffha_pkg.sv
package pffha_pkg;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_ZERO     = 3'd1;
  localparam status_t ST_TOO_BIG  = 3'd2;
  localparam status_t ST_NO_PAGE  = 3'd3;
  localparam status_t ST_NO_ROOM  = 3'd4;

  // Request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PRD,
    S_PCHK,
    S_WSTART,
    S_LWAIT,
    S_HRD,
    S_HCHK,
    S_BUMP,
    S_FRD,
    S_FCHK,
    S_DONE
  } state_t;

endpackage

>>> hdl/pffha_if.sv
// Request channel: allocate or free.
interface pffha_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] request_bytes;
  logic [15:0] free_address;
  modport source (output valid, action, request_bytes, free_address, input ready);
  modport sink (input valid, action, request_bytes, free_address, output ready);
endinterface

// Response channel: status and block address.
interface pffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] block_address;
  modport source (output valid, status, block_address, input ready);
  modport sink (input valid, status, block_address, output ready);
endinterface

>>> hdl/paged_first_fit_heap_allocator.sv
// First-fit heap allocator over NUM_PAGES pages of PAGE_BYTES bytes. One request is taken
// at a time, and ready is high only while idle. A rejected request (zero size, too large,
// or a free at a bad address) goes straight to the response. A valid free reads the block
// header and, if the block is in use, clears its used bit and credits the page. An allocate
// scans page counters from page 0 for one with room, opens a new page if none has room, or
// answers no page when all pages are in use. It then walks the chosen page's block headers
// from the first for a free block large enough to reuse; if none is found, or the page has
// no blocks yet, the request is bump-placed after the last block or finds no room. Both
// walks read a registered memory (page counters, block headers), each entry read in one
// state and checked in another. The response is held in an output register until taken,
// and the allocator stays busy while rsp.ready is low.
module paged_first_fit_heap_allocator #(
  parameter int PAGE_BYTES        = 4096,
  parameter int NUM_PAGES         = 16,
  parameter int PAGE_HEADER_BYTES = 12
) (
  input logic clk,
  input logic rst,
  pffha_req_if.sink   req,
  pffha_rsp_if.source rsp
);
  import pffha_pkg::*;

  localparam int PB         = $clog2(PAGE_BYTES);
  localparam int WB         = PB - 2;
  localparam int OW         = PB + 2;
  localparam int FIRST_OFF  = ((PAGE_HEADER_BYTES + 3) / 4) * 4;
  localparam int PAGE_CAP   = PAGE_BYTES - FIRST_OFF;
  localparam int PAGE_WORDS = PAGE_BYTES / 4;
  localparam int PGW        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW         = $clog2(NUM_PAGES + 1);
  localparam int HAW        = PGW + WB;
  localparam int HDEPTH     = NUM_PAGES * PAGE_WORDS;

  // Storage
  logic [PB-1:0] hdr_mem [HDEPTH];
  logic [PB-1:0] pf_mem  [NUM_PAGES];
  logic [WB-1:0] lo_mem  [NUM_PAGES];
  logic [NUM_PAGES-1:0] has_blocks;
  logic          p0_valid;

  state_t        state, state_next;
  logic [PGW-1:0] pg;
  logic [CW-1:0]  piu;
  logic [PB-1:0]  size;
  logic [OW-1:0]  off, last;
  logic [PB-1:0]  cur_free;
  logic [HAW-1:0] haddr;
  status_t        out_status;
  logic [15:0]    out_addr;

  logic [PB-1:0] hdr_rd, pf_rd;
  logic [WB-1:0] lo_rd;
  logic          pf_rd_cap;
  logic [PB-1:0] pf_val;

  // Combinational request decode
  logic [16:0]   rsize;
  logic          too_big;
  logic [31:0]   fa_pg, fa_off;
  logic          fa_bad;

  logic [HAW-1:0] hdr_addr;
  logic           hdr_we, pf_we, lo_we;
  logic [PB-1:0]  hdr_wd, pf_wd;
  logic [PGW-1:0] pf_waddr;

  logic          h_used;
  logic [PB-1:0] h_size;
  logic          walk_go, page_short, more_pages;
  logic [PB:0]   charge_amt, charge_res, credit_sum;
  logic [31:0]   addr_calc;

  assign rsize   = (17'({1'b0, req.request_bytes}) + 17'd3) & ~17'd3;
  assign too_big = (32'(FIRST_OFF) + 32'd4 + 32'(rsize)) > 32'(PAGE_BYTES);
  assign fa_pg   = 32'(req.free_address) >> PB;
  assign fa_off  = 32'(req.free_address) & 32'(PAGE_BYTES - 1);
  assign fa_bad  = (req.free_address[1:0] != 2'b00) || (fa_pg >= 32'(piu)) ||
                   (fa_off < 32'(FIRST_OFF + 4));

  assign pf_val     = pf_rd_cap ? PB'(PAGE_CAP) : pf_rd;
  assign h_used     = hdr_rd[0];
  assign h_size     = {hdr_rd[PB-1:2], 2'b00};
  assign walk_go    = (off <= last) && (off < OW'(PAGE_BYTES));
  assign page_short = pf_val < size;
  assign more_pages = (32'(pg) + 32'd1) < 32'(piu);
  assign addr_calc  = 32'(pg) * 32'(PAGE_BYTES) + 32'(off) + 32'd4;
  assign credit_sum = {1'b0, pf_val} + {1'b0, h_size};

  // Saturating charge against the chosen page
  always_comb begin
    charge_amt = (state == S_HCHK) ? {1'b0, h_size} : ({1'b0, size} + (PB+1)'(4));
    charge_res = ({1'b0, cur_free} >= charge_amt) ? ({1'b0, cur_free} - charge_amt) : '0;
  end

  assign hdr_addr = (state == S_FRD || state == S_FCHK) ? haddr : {pg, off[PB-1:2]};

  // Memories
  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_addr] <= hdr_wd;
    hdr_rd <= hdr_mem[hdr_addr];
  end

  always_ff @(posedge clk) begin
    if (pf_we) pf_mem[pf_waddr] <= pf_wd;
    pf_rd <= pf_mem[pg];
    pf_rd_cap <= (pg == '0) && !p0_valid;
  end

  always_ff @(posedge clk) begin
    if (lo_we) lo_mem[pg] <= off[PB-1:2];
    lo_rd <= lo_mem[pg];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.action == ACT_FREE) state_next = fa_bad ? S_DONE : S_FRD;
          else if (req.request_bytes == 16'd0 || too_big) state_next = S_DONE;
          else state_next = S_PRD;
        end
      end
      S_PRD:  state_next = S_PCHK;
      S_PCHK: begin
        if (page_short && more_pages) state_next = S_PRD;
        else if (page_short && piu >= CW'(NUM_PAGES)) state_next = S_DONE;
        else state_next = S_WSTART;
      end
      S_WSTART: state_next = has_blocks[pg] ? S_LWAIT : S_BUMP;
      S_LWAIT:  state_next = S_HRD;
      S_HRD:    state_next = walk_go ? S_HCHK : S_BUMP;
      S_HCHK:   state_next = (!h_used && h_size >= size) ? S_DONE : S_HRD;
      S_BUMP:   state_next = S_DONE;
      S_FRD:    state_next = S_FCHK;
      S_FCHK:   state_next = S_DONE;
      S_DONE:   state_next = rsp.ready ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory write controls
  always_comb begin
    hdr_we   = 1'b0;
    hdr_wd   = '0;
    pf_we    = 1'b0;
    pf_wd    = '0;
    pf_waddr = pg;
    lo_we    = 1'b0;
    unique case (state)
      S_PCHK: begin
        if (page_short && !more_pages && piu < CW'(NUM_PAGES)) begin
          pf_we    = 1'b1;
          pf_waddr = PGW'(piu);
          pf_wd    = PB'(PAGE_CAP);
        end
      end
      S_HCHK: begin
        if (!h_used && h_size >= size) begin
          hdr_we = 1'b1;
          hdr_wd = h_size | PB'(1);
          pf_we  = 1'b1;
          pf_wd  = charge_res[PB-1:0];
        end
      end
      S_BUMP: begin
        if ((32'(off) + 32'd4 + 32'(size)) <= 32'(PAGE_BYTES)) begin
          hdr_we = 1'b1;
          hdr_wd = size | PB'(1);
          pf_we  = 1'b1;
          pf_wd  = charge_res[PB-1:0];
          lo_we  = 1'b1;
        end
      end
      S_FCHK: begin
        if (h_used) begin
          hdr_we = 1'b1;
          hdr_wd = h_size;
          pf_we  = 1'b1;
          pf_wd  = (credit_sum > (PB+1)'(PAGE_CAP)) ? PB'(PAGE_CAP) : credit_sum[PB-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      piu        <= CW'(1);
      has_blocks <= '0;
      p0_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (pf_we && pf_waddr == '0) p0_valid <= 1'b1;
      if (state == S_PCHK && page_short && !more_pages && piu < CW'(NUM_PAGES)) begin
        piu <= piu + CW'(1);
        has_blocks[PGW'(piu)] <= 1'b0;
      end
      if (lo_we) has_blocks[pg] <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        out_status <= ST_OK;
        out_addr   <= '0;
        size       <= rsize[PB-1:0];
        off        <= OW'(FIRST_OFF);
        if (req.action == ACT_FREE) begin
          pg    <= PGW'(fa_pg);
          haddr <= HAW'(fa_pg * 32'(PAGE_WORDS) + (fa_off >> 2) - 32'd1);
        end else begin
          pg <= '0;
          if (req.request_bytes == 16'd0) out_status <= ST_ZERO;
          else if (too_big) out_status <= ST_TOO_BIG;
        end
      end
      S_PCHK: begin
        cur_free <= pf_val;
        if (page_short && more_pages) pg <= pg + PGW'(1);
        else if (page_short && piu >= CW'(NUM_PAGES)) out_status <= ST_NO_PAGE;
        else if (page_short) begin
          pg       <= PGW'(piu);
          cur_free <= PB'(PAGE_CAP);
        end
      end
      S_LWAIT: last <= OW'({lo_rd, 2'b00});
      S_HCHK: begin
        if (!h_used && h_size >= size) out_addr <= addr_calc[15:0];
        else off <= off + OW'(h_size) + OW'(4);
      end
      S_BUMP: begin
        if ((32'(off) + 32'd4 + 32'(size)) > 32'(PAGE_BYTES)) out_status <= ST_NO_ROOM;
        else out_addr <= addr_calc[15:0];
      end
      default: begin
      end
    endcase
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = (state == S_DONE);
  assign rsp.status        = out_status;
  assign rsp.block_address = out_addr;

`include "paged_first_fit_heap_allocator_assert.svh"

  `PFFHA_ASSERT_NOW(a_err_addr_zero, rsp.valid && rsp.status != ST_OK, rsp.block_address == 16'd0)
  `PFFHA_ASSERT_NOW(a_piu_range, 1'b1, piu >= CW'(1) && piu <= CW'(NUM_PAGES))
  `PFFHA_ASSERT_NOW(a_ready_excl, req.ready, !rsp.valid)
  `PFFHA_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready)

endmodule

>>> tb/paged_first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

module paged_first_fit_heap_allocator_tb;
  import pffha_pkg::*;

  localparam int PAGE_BYTES = 4096;
  localparam int NUM_PAGES = 16;
  localparam int PAGE_HEADER_BYTES = 12;
  localparam int FIRST_OFF = (PAGE_HEADER_BYTES + 3) & ~3;
  localparam int PAGE_CAP = PAGE_BYTES - FIRST_OFF;
  localparam int PAGE_WORDS = PAGE_BYTES / 4;
  localparam int HDR_WORDS = NUM_PAGES * PAGE_WORDS;
  localparam int MAX_SIZE = PAGE_BYTES - FIRST_OFF - 4;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    status_t     status;
    logic [15:0] addr;
  } alloc_rsp_t;

  typedef struct {
    logic        action;
    logic [15:0] bytes;
    logic [15:0] addr;
    bit          typed;
    status_t     status;
    logic [15:0] exp_addr;
  } stim_row_t;

  logic clk;
  logic rst;
  pffha_req_if req ();
  pffha_rsp_if rsp ();

  paged_first_fit_heap_allocator #(
    .PAGE_BYTES(PAGE_BYTES),
    .NUM_PAGES(NUM_PAGES),
    .PAGE_HEADER_BYTES(PAGE_HEADER_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Heap shadow state
  int unsigned hdr_word [HDR_WORDS];
  bit          hdr_written [HDR_WORDS];
  int unsigned page_free [NUM_PAGES];
  int unsigned page_last [NUM_PAGES];
  bit          page_used [NUM_PAGES];
  int unsigned active_pages;

  alloc_rsp_t  pending_rsp [$];
  logic [15:0] live_blocks [$];
  stim_row_t   rows [$];
  bit          failed;
  bit          quiet_rx;
  int          rsp_count;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void heap_reset();
    for (int i = 0; i < HDR_WORDS; i++) begin
      hdr_word[i] = 0;
      hdr_written[i] = 1'b0;
    end
    for (int p = 0; p < NUM_PAGES; p++) begin
      page_free[p] = PAGE_CAP;
      page_last[p] = 0;
      page_used[p] = 1'b0;
    end
    active_pages = 1;
  endfunction

  function automatic void page_charge(int unsigned pg, int unsigned amount);
    page_free[pg] = (page_free[pg] >= amount) ? page_free[pg] - amount : 0;
  endfunction

  // First-fit placement inside one page
  function automatic status_t place_block(int unsigned pg, int unsigned size,
                                          output logic [15:0] addr);
    int unsigned base;
    int unsigned off;
    int unsigned last;
    int unsigned idx;
    int unsigned bsize;
    base = pg * PAGE_WORDS;
    off = FIRST_OFF;
    addr = '0;
    if (page_used[pg]) begin
      last = page_last[pg] * 4;
      while (off <= last && off < PAGE_BYTES) begin
        idx = base + off / 4;
        bsize = hdr_word[idx] & ~3;
        if (!hdr_word[idx][0] && bsize >= size) begin
          hdr_word[idx] = bsize | 1;
          page_charge(pg, bsize);
          addr = 16'(pg * PAGE_BYTES + off + 4);
          return ST_OK;
        end
        off += bsize + 4;
      end
    end
    if (off + 4 + size > PAGE_BYTES) return ST_NO_ROOM;
    idx = base + off / 4;
    hdr_word[idx] = size | 1;
    hdr_written[idx] = 1'b1;
    page_charge(pg, size + 4);
    page_last[pg] = off / 4;
    page_used[pg] = 1'b1;
    addr = 16'(pg * PAGE_BYTES + off + 4);
    return ST_OK;
  endfunction

  function automatic alloc_rsp_t heap_alloc(int unsigned bytes);
    alloc_rsp_t r;
    int unsigned size;
    int unsigned pg;
    r.addr = '0;
    if (bytes == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    size = (bytes + 3) & ~3;
    if (FIRST_OFF + 4 + size > PAGE_BYTES) begin
      r.status = ST_TOO_BIG;
      return r;
    end
    pg = 0;
    while (pg + 1 < active_pages && page_free[pg] < size) pg++;
    if (page_free[pg] < size) begin
      if (active_pages >= NUM_PAGES) begin
        r.status = ST_NO_PAGE;
        return r;
      end
      pg = active_pages;
      active_pages++;
      page_free[pg] = PAGE_CAP;
      page_used[pg] = 1'b0;
    end
    r.status = place_block(pg, size, r.addr);
    if (r.status != ST_OK) r.addr = '0;
    return r;
  endfunction

  function automatic void heap_free(int unsigned a);
    int unsigned pg;
    int unsigned idx;
    int unsigned bsize;
    if (a[1:0] != 0) return;
    pg = a / PAGE_BYTES;
    if (pg >= active_pages) return;
    if (a % PAGE_BYTES < FIRST_OFF + 4) return;
    idx = (a - 4) / 4;
    if (!hdr_word[idx][0]) return;
    bsize = hdr_word[idx] & ~3;
    hdr_word[idx] = bsize;
    page_free[pg] = (page_free[pg] + bsize > PAGE_CAP) ? PAGE_CAP : page_free[pg] + bsize;
  endfunction

  // Would this free read a header that was never written?
  function automatic bit is_stray(logic [15:0] a);
    int unsigned pg;
    pg = a / PAGE_BYTES;
    if (a[1:0] != 0 || pg >= active_pages || a % PAGE_BYTES < FIRST_OFF + 4) return 1'b0;
    return !hdr_written[(a - 4) / 4];
  endfunction

  function automatic int unsigned pick_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return $urandom_range(1, 64);
    if (k < 85) return $urandom_range(65, 600);
    if (k < 94) return $urandom_range(601, MAX_SIZE);
    if (k < 96) return 0;
    if (k < 98) return $urandom_range(MAX_SIZE + 1, MAX_SIZE + 8);
    return $urandom_range(0, 65535);
  endfunction

  // Directed rows: fill every page, exhaust the pool, edge sizes, bad frees
  task automatic load_directed();
    for (int p = 0; p < NUM_PAGES; p++)
      rows.push_back('{ACT_ALLOC, 16'(MAX_SIZE), 16'hffff, 1'b1, ST_OK,
                       16'(p * PAGE_BYTES + FIRST_OFF + 4)});
    rows.push_back('{ACT_ALLOC, 16'(MAX_SIZE), 16'h0, 1'b1, ST_NO_PAGE, 16'h0});
    rows.push_back('{ACT_ALLOC, 16'h0, 16'hffff, 1'b1, ST_ZERO, 16'h0});
    rows.push_back('{ACT_ALLOC, 16'(MAX_SIZE + 1), 16'h0, 1'b1, ST_TOO_BIG, 16'h0});
    rows.push_back('{ACT_ALLOC, 16'hffff, 16'h0, 1'b1, ST_TOO_BIG, 16'h0});
    rows.push_back('{ACT_FREE, 16'hffff, 16'(FIRST_OFF + 4), 1'b1, ST_OK, 16'h0});
    rows.push_back('{ACT_FREE, 16'h0, 16'(FIRST_OFF + 4), 1'b1, ST_OK, 16'h0});
    rows.push_back('{ACT_FREE, 16'h0, 16'hffff, 1'b1, ST_OK, 16'h0});
    rows.push_back('{ACT_FREE, 16'h0, 16'h0, 1'b1, ST_OK, 16'h0});
    rows.push_back('{ACT_ALLOC, 16'h1, 16'h0, 1'b0, ST_OK, 16'h0});
  endtask

  // Offer one request and wait for it to be taken
  task automatic send_request(logic action, logic [15:0] bytes, logic [15:0] addr,
                              bit typed, status_t t_status, logic [15:0] t_addr);
    int gap;
    alloc_rsp_t r;
    gap = quiet_rx ? 0 : (($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)));
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= action;
    req.request_bytes <= bytes;
    req.free_address <= addr;
    do @(posedge clk); while (!req.ready);
    r.status = ST_OK;
    r.addr = '0;
    if (action == ACT_ALLOC) r = heap_alloc(bytes);
    else heap_free(addr);
    if (action == ACT_ALLOC && r.status == ST_OK) live_blocks.push_back(r.addr);
    if (typed) begin
      r.status = t_status;
      r.addr = t_addr;
    end
    pending_rsp.push_back(r);
  endtask

  // Stimulus
  initial begin
    logic [15:0] a;
    int          k;
    int          j;
    req.valid = 1'b0;
    req.action = ACT_ALLOC;
    req.request_bytes = '0;
    req.free_address = '0;
    rst = 1'b1;
    failed = 1'b0;
    quiet_rx = 1'b0;
    heap_reset();
    load_directed();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send_request(rows[i].action, rows[i].bytes, rows[i].addr, rows[i].typed,
                   rows[i].status, rows[i].exp_addr);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_rx = (n >= 1200 && n < 1350);
      if (n == 800) begin
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      k = $urandom_range(0, 99);
      if (k < 45 && live_blocks.size() != 0) begin
        j = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[j];
        if ($urandom_range(0, 9) != 0) live_blocks.delete(j);
        send_request(ACT_FREE, 16'($urandom), a, 1'b0, ST_OK, 16'h0);
      end else if (k < 95) begin
        send_request(ACT_ALLOC, 16'(pick_size()), 16'($urandom), 1'b0, ST_OK, 16'h0);
      end else begin
        a = 16'($urandom);
        if (is_stray(a)) a[0] = 1'b1;
        send_request(ACT_FREE, 16'($urandom), a, 1'b0, ST_OK, 16'h0);
      end
    end
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Response side: random stalls, one long hold-off, quiet stretch
  int stall_left;
  bit long_done;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
      long_done <= 1'b0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_done && rsp_count >= 300) begin
      rsp.ready <= 1'b0;
      stall_left <= 400;
      long_done <= 1'b1;
    end else if (quiet_rx) begin
      rsp.ready <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(20, 60);
    end else begin
      rsp.ready <= ($urandom_range(0, 9) >= 3);
    end
  end

  // Result check
  alloc_rsp_t want;
  always @(posedge clk) begin
    if (rst) begin
      rsp_count <= 0;
    end else if (rsp.valid && rsp.ready) begin
      rsp_count <= rsp_count + 1;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response status=%0d addr=%0h", $time, rsp.status,
                 rsp.block_address);
        failed = 1'b1;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                   rsp.status);
          failed = 1'b1;
        end
        if (rsp.block_address !== want.addr) begin
          $display("%0t: block_address mismatch expected=%0h actual=%0h", $time, want.addr,
                   rsp.block_address);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d responses pending", $time, pending_rsp.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
+incdir+hdl
hdl/pffha_pkg.sv
hdl/pffha_if.sv
hdl/paged_first_fit_heap_allocator.sv
tb/paged_first_fit_heap_allocator_tb.sv
